FILE: rtl/lsm_pkg.sv
// shared constants, types and helpers for the ldu sparse matrix-vector block
package lsm_pkg;

  localparam int MAX_CELLS = 1024;
  localparam int CELL_AW   = $clog2(MAX_CELLS);

  localparam logic signed [47:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] SUM_MIN = 48'sh8000_0000_0000;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_FACE = 2'd1,
    OP_READ = 2'd2
  } lsm_op_t;

  // which captured operand a datapath step works on
  typedef enum logic [1:0] {
    SEL_CELL  = 2'd0,
    SEL_LOWER = 2'd1,
    SEL_UPPER = 2'd2
  } lsm_sel_t;

  typedef struct packed {
    logic     capture;
    logic     vec_rd;
    logic     mul_en;
    lsm_sel_t mul_sel;
    logic     prod_rd;
    lsm_sel_t prod_sel;
    logic     load_wr;
    logic     acc_wr;
    logic     out_en;
  } lsm_cmd_t;

  function automatic logic cell_ok(input logic [9:0] idx);
    return 32'(idx) < 32'(MAX_CELLS);
  endfunction

  function automatic logic [CELL_AW-1:0] to_addr(input logic [9:0] idx);
    return CELL_AW'(idx);
  endfunction

endpackage

FILE: rtl/lsm_ctrl.sv
// sequencer for load, face and read transactions
module lsm_ctrl import lsm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] op,
  output logic       busy,
  output logic       done,
  output lsm_cmd_t   ctl
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_L_MUL,
    S_L_WR,
    S_F_RDV,
    S_F_MUL_LO,
    S_F_ACC_UP,
    S_F_RD_LO,
    S_F_ACC_LO,
    S_R_RD,
    S_R_OUT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (op)
            OP_LOAD: state_next = S_L_MUL;
            OP_FACE: state_next = S_F_RDV;
            OP_READ: state_next = S_R_RD;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_L_MUL:    state_next = S_L_WR;
      S_L_WR:     state_next = S_IDLE;
      S_F_RDV:    state_next = S_F_MUL_LO;
      S_F_MUL_LO: state_next = S_F_ACC_UP;
      S_F_ACC_UP: state_next = S_F_RD_LO;
      S_F_RD_LO:  state_next = S_F_ACC_LO;
      S_F_ACC_LO: state_next = S_IDLE;
      S_R_RD:     state_next = S_R_OUT;
      S_R_OUT:    state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl          = '0;
    ctl.mul_sel  = SEL_CELL;
    ctl.prod_sel = SEL_CELL;
    unique case (state)
      S_IDLE:  ctl.capture = start;
      S_L_MUL: ctl.mul_en  = 1'b1;
      S_L_WR:  ctl.load_wr = 1'b1;
      S_F_RDV: ctl.vec_rd  = 1'b1;
      S_F_MUL_LO: begin
        ctl.mul_en   = 1'b1;
        ctl.mul_sel  = SEL_LOWER;
        ctl.prod_rd  = 1'b1;
        ctl.prod_sel = SEL_UPPER;
      end
      S_F_ACC_UP: begin
        ctl.acc_wr   = 1'b1;
        ctl.prod_sel = SEL_UPPER;
        ctl.mul_en   = 1'b1;
        ctl.mul_sel  = SEL_UPPER;
      end
      // lower cell read waits for the upper write, so a self face sees both sums
      S_F_RD_LO: begin
        ctl.prod_rd  = 1'b1;
        ctl.prod_sel = SEL_LOWER;
      end
      S_F_ACC_LO: begin
        ctl.acc_wr   = 1'b1;
        ctl.prod_sel = SEL_LOWER;
      end
      S_R_RD:  ctl.prod_rd = 1'b1;
      S_R_OUT: ctl.out_en  = 1'b1;
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
      done  <= (state == S_R_OUT);
    end
  end

endmodule

FILE: rtl/lsm_datapath.sv
// operand registers, vector and product memories, multiplier and saturating adder
module lsm_datapath import lsm_pkg::*; (
  input  logic               clk,
  input  lsm_cmd_t           ctl,
  input  logic [9:0]         cell_index,
  input  logic signed [31:0] diag_coeff,
  input  logic signed [31:0] psi_value,
  input  logic [9:0]         lower_cell,
  input  logic [9:0]         upper_cell,
  input  logic signed [31:0] lower_coeff,
  input  logic signed [31:0] upper_coeff,
  output logic [9:0]         result_cell,
  output logic signed [47:0] product_value,
  output logic               saturated
);

  logic [9:0]         cell_q;
  logic [9:0]         lo_q;
  logic [9:0]         up_q;
  logic signed [31:0] diag_q;
  logic signed [31:0] psi_q;
  logic signed [31:0] lc_q;
  logic signed [31:0] uc_q;
  logic               cell_ok_q;
  logic               lo_ok_q;
  logic               up_ok_q;

  logic signed [31:0] vec_mem [MAX_CELLS];
  logic [48:0]        prod_mem [MAX_CELLS];

  logic signed [31:0] vec_lo_q;
  logic signed [31:0] vec_up_q;
  logic signed [47:0] mul_q;
  logic [48:0]        prod_rd_q;

  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] mul_full;
  logic [9:0]         sel_idx;
  logic               sel_ok;
  logic signed [48:0] sum_wide;
  logic signed [47:0] sum_sat;
  logic               sum_ovf;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cell_q    <= cell_index;
      lo_q      <= lower_cell;
      up_q      <= upper_cell;
      diag_q    <= diag_coeff;
      psi_q     <= psi_value;
      lc_q      <= lower_coeff;
      uc_q      <= upper_coeff;
      cell_ok_q <= cell_ok(cell_index);
      lo_ok_q   <= cell_ok(lower_cell);
      up_ok_q   <= cell_ok(upper_cell);
    end
  end

  always_comb begin
    case (ctl.prod_sel)
      SEL_LOWER: begin
        sel_idx = lo_q;
        sel_ok  = lo_ok_q;
      end
      SEL_UPPER: begin
        sel_idx = up_q;
        sel_ok  = up_ok_q;
      end
      default: begin
        sel_idx = cell_q;
        sel_ok  = cell_ok_q;
      end
    endcase
  end

  always_comb begin
    case (ctl.mul_sel)
      SEL_LOWER: begin
        mul_a = lc_q;
        mul_b = vec_lo_q;
      end
      SEL_UPPER: begin
        mul_a = uc_q;
        mul_b = vec_up_q;
      end
      default: begin
        mul_a = diag_q;
        mul_b = psi_q;
      end
    endcase
  end

  // q16.16 x q16.16, dropping 16 fraction bits floors toward minus infinity
  assign mul_full = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      mul_q <= mul_full[63:16];
    end
  end

  assign sum_wide = {prod_rd_q[47], prod_rd_q[47:0]} + {mul_q[47], mul_q};
  assign sum_ovf  = sum_wide[48] != sum_wide[47];
  assign sum_sat  = !sum_ovf ? sum_wide[47:0] : (sum_wide[48] ? SUM_MIN : SUM_MAX);

  always_ff @(posedge clk) begin
    if (ctl.load_wr && cell_ok_q) begin
      vec_mem[to_addr(cell_q)] <= psi_q;
    end
    if (ctl.vec_rd) begin
      vec_lo_q <= lo_ok_q ? vec_mem[to_addr(lo_q)] : '0;
      vec_up_q <= up_ok_q ? vec_mem[to_addr(up_q)] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_wr && cell_ok_q) begin
      prod_mem[to_addr(cell_q)] <= {1'b0, mul_q};
    end else if (ctl.acc_wr && sel_ok) begin
      prod_mem[to_addr(sel_idx)] <= {prod_rd_q[48] | sum_ovf, sum_sat};
    end
    if (ctl.prod_rd) begin
      prod_rd_q <= prod_mem[to_addr(sel_idx)];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_en) begin
      result_cell   <= cell_q;
      product_value <= cell_ok_q ? prod_rd_q[47:0] : '0;
      saturated     <= cell_ok_q & prod_rd_q[48];
    end
  end

endmodule

FILE: rtl/ldu_sparse_matvec.sv
// top level of the ldu face-addressed sparse matrix-vector block
// Items are taken when start is high and busy is low; busy then stays high
// until the block can take the next one (an unused command code is taken
// without raising busy). A read's result appears with done, registered from
// the read's output state, for exactly one cycle, and cannot be held off. The
// sequencing comes from the single shared 32x32 multiplier and the one write
// port of the product memory, which a face updates twice in order (upper cell
// first). Memories are not cleared: a face or read touching a never-loaded
// cell gives undefined data.
module ldu_sparse_matvec import lsm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd,
  input  logic [9:0]         cell_index,
  input  logic signed [31:0] diag_coeff,
  input  logic signed [31:0] psi_value,
  input  logic [9:0]         lower_cell,
  input  logic [9:0]         upper_cell,
  input  logic signed [31:0] lower_coeff,
  input  logic signed [31:0] upper_coeff,
  output logic               done,
  output logic [9:0]         result_cell,
  output logic signed [47:0] product_value,
  output logic               saturated
);

  lsm_cmd_t ctl;

  lsm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (cmd),
    .busy  (busy),
    .done  (done),
    .ctl   (ctl)
  );

  lsm_datapath u_datapath (
    .clk           (clk),
    .ctl           (ctl),
    .cell_index    (cell_index),
    .diag_coeff    (diag_coeff),
    .psi_value     (psi_value),
    .lower_cell    (lower_cell),
    .upper_cell    (upper_cell),
    .lower_coeff   (lower_coeff),
    .upper_coeff   (upper_coeff),
    .result_cell   (result_cell),
    .product_value (product_value),
    .saturated     (saturated)
  );

endmodule

FILE: rtl/lsm_checker.sv
// port-level checks for the ldu sparse matrix-vector block, with bind
module lsm_checker import lsm_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] cmd,
  input logic [9:0] cell_index,
  input logic       done,
  input logic [9:0] result_cell
);

  logic accept;
  assign accept = start && !busy;

  a_read_result: assert property (@(posedge clk) disable iff (rst)
    accept && cmd == OP_READ |-> ##3 (done && result_cell == $past(cell_index, 3)))
    else $error("read transaction did not return its cell on time");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    accept && cmd != OP_READ |=> !done)
    else $error("result strobe after a non-read transaction");

  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd == OP_LOAD || cmd == OP_FACE || cmd == OP_READ) |=> busy)
    else $error("busy not raised after an accepted transaction");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("result strobe outside the end of a read");

endmodule

bind ldu_sparse_matvec lsm_checker u_lsm_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .cmd         (cmd),
  .cell_index  (cell_index),
  .done        (done),
  .result_cell (result_cell)
);

FILE: tb/sv/ldu_sparse_matvec_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the ldu face-addressed sparse matrix-vector block
module ldu_sparse_matvec_tb;
  import lsm_pkg::*;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         RANDOM_ITEMS = 2000;
  localparam int         CYCLE_LIMIT  = 600000;
  localparam int         DRAIN_CYCLES = 8;

  typedef struct {
    logic [1:0]  cmd;
    logic [9:0]  cell_id;
    logic [31:0] diag;
    logic [31:0] psi;
    logic [9:0]  lo;
    logic [9:0]  up;
    logic [31:0] lc;
    logic [31:0] uc;
  } lsm_item_t;

  typedef struct {
    logic [9:0]         cell_id;
    logic signed [47:0] value;
    logic               sat;
  } cell_product_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         cmd = '0;
  logic [9:0]         cell_index = '0;
  logic signed [31:0] diag_coeff = '0;
  logic signed [31:0] psi_value = '0;
  logic [9:0]         lower_cell = '0;
  logic [9:0]         upper_cell = '0;
  logic signed [31:0] lower_coeff = '0;
  logic signed [31:0] upper_coeff = '0;
  logic               done;
  logic [9:0]         result_cell;
  logic signed [47:0] product_value;
  logic               saturated;

  ldu_sparse_matvec dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .cell_index    (cell_index),
    .diag_coeff    (diag_coeff),
    .psi_value     (psi_value),
    .lower_cell    (lower_cell),
    .upper_cell    (upper_cell),
    .lower_coeff   (lower_coeff),
    .upper_coeff   (upper_coeff),
    .done          (done),
    .result_cell   (result_cell),
    .product_value (product_value),
    .saturated     (saturated)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // local copy of the cell memories
  logic signed [31:0] vec_model  [0:MAX_CELLS-1];
  logic signed [47:0] prod_model [0:MAX_CELLS-1];
  bit                 sat_model  [0:MAX_CELLS-1];
  bit                 loaded     [0:MAX_CELLS-1];
  int                 loaded_list[$];

  cell_product_t pending_products[$];
  cell_product_t want;

  int load_count    = 0;
  int face_count    = 0;
  int read_count    = 0;
  int ignored_count = 0;
  int result_count  = 0;
  int sat_reads     = 0;
  int error_count   = 0;
  int cycle_count   = 0;

  // q16.16 times q16.16, fraction dropped towards minus infinity
  function automatic logic signed [47:0] q_mul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p[63:16];
  endfunction

  function automatic void add_sat(input int idx, input logic signed [47:0] addend);
    logic signed [48:0] s;
    s = prod_model[idx] + addend;
    if (s > SUM_MAX) begin
      s = SUM_MAX;
      sat_model[idx] = 1'b1;
    end else if (s < SUM_MIN) begin
      s = SUM_MIN;
      sat_model[idx] = 1'b1;
    end
    prod_model[idx] = s[47:0];
  endfunction

  task automatic predict_item(input lsm_item_t it);
    cell_product_t r;
    case (it.cmd)
      OP_LOAD: begin
        vec_model[it.cell_id]  = it.psi;
        prod_model[it.cell_id] = q_mul(it.diag, it.psi);
        sat_model[it.cell_id]  = 1'b0;
        if (!loaded[it.cell_id]) begin
          loaded[it.cell_id] = 1'b1;
          loaded_list.push_back(int'(it.cell_id));
        end
        load_count++;
      end
      OP_FACE: begin
        // upper cell first, then lower cell
        add_sat(it.up, q_mul(it.lc, vec_model[it.lo]));
        add_sat(it.lo, q_mul(it.uc, vec_model[it.up]));
        face_count++;
      end
      OP_READ: begin
        r.cell_id = it.cell_id;
        r.value   = prod_model[it.cell_id];
        r.sat     = sat_model[it.cell_id];
        pending_products.push_back(r);
        read_count++;
      end
      default: ignored_count++;
    endcase
  endtask

  function automatic lsm_item_t random_item();
    lsm_item_t it;
    it.cmd     = 2'($urandom_range(0, 3));
    it.cell_id = 10'($urandom);
    it.diag    = $urandom;
    it.psi     = $urandom;
    it.lo      = 10'($urandom);
    it.up      = 10'($urandom);
    it.lc      = $urandom;
    it.uc      = $urandom;
    return it;
  endfunction

  function automatic lsm_item_t mk_load(input int c, input logic [31:0] d,
                                        input logic [31:0] v);
    lsm_item_t it;
    it = random_item();
    it.cmd     = OP_LOAD;
    it.cell_id = 10'(c);
    it.diag    = d;
    it.psi     = v;
    return it;
  endfunction

  function automatic lsm_item_t mk_face(input int l, input int u,
                                        input logic [31:0] lcoef,
                                        input logic [31:0] ucoef);
    lsm_item_t it;
    it = random_item();
    it.cmd = OP_FACE;
    it.lo  = 10'(l);
    it.up  = 10'(u);
    it.lc  = lcoef;
    it.uc  = ucoef;
    return it;
  endfunction

  function automatic lsm_item_t mk_read(input int c);
    lsm_item_t it;
    it = random_item();
    it.cmd     = OP_READ;
    it.cell_id = 10'(c);
    return it;
  endfunction

  function automatic lsm_item_t mk_unused();
    lsm_item_t it;
    it = random_item();
    it.cmd = OP_UNUSED;
    return it;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int next_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] pick_q(input int mode, input bit neg);
    logic [31:0] mag;
    case (mode)
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 6))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'h0000_0001;
          4: return 32'hFFFF_FFFF;
          5: return 32'h0001_0000;
          default: return 32'hFFFF_0000;
        endcase
      end
      2: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
      default: begin
        // large magnitudes of one sign drive sums into saturation
        mag = $urandom_range(32'h2000_0000, 32'h7FFF_FFFF);
        return neg ? -mag : mag;
      end
    endcase
  endfunction

  // called at a rising edge; returns gap edges after the accepting edge
  task automatic send_item(input lsm_item_t it, input int gap);
    start       <= 1'b1;
    cmd         <= it.cmd;
    cell_index  <= it.cell_id;
    diag_coeff  <= it.diag;
    psi_value   <= it.psi;
    lower_cell  <= it.lo;
    upper_cell  <= it.up;
    lower_coeff <= it.lc;
    upper_coeff <= it.uc;
    do @(posedge clk); while (busy);
    predict_item(it);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic test_load_read_extremes;
    send_item(mk_load(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF), next_gap(1'b0));
    send_item(mk_load(1023, 32'h8000_0000, 32'h8000_0000), next_gap(1'b0));
    send_item(mk_load(5, 32'h8000_0000, 32'h7FFF_FFFF), next_gap(1'b0));
    // minus one lsb times one lsb rounds down to minus one
    send_item(mk_load(3, 32'hFFFF_FFFF, 32'h0000_0001), next_gap(1'b0));
    send_item(mk_load(512, 32'h0000_0000, 32'h8000_0000), next_gap(1'b0));
    send_item(mk_read(0), next_gap(1'b0));
    send_item(mk_read(1023), next_gap(1'b0));
    send_item(mk_read(5), next_gap(1'b0));
    send_item(mk_read(3), next_gap(1'b0));
    send_item(mk_read(512), next_gap(1'b0));
  endtask

  task automatic test_face_saturation;
    // same cell on both sides, positive overflow
    send_item(mk_face(0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF), next_gap(1'b0));
    send_item(mk_read(0), next_gap(1'b0));
    // negative overflow
    send_item(mk_load(9, 32'h7FFF_FFFF, 32'h8000_0000), next_gap(1'b0));
    send_item(mk_face(9, 9, 32'h7FFF_FFFF, 32'h7FFF_FFFF), next_gap(1'b0));
    send_item(mk_face(9, 9, 32'h7FFF_FFFF, 32'h7FFF_FFFF), next_gap(1'b0));
    send_item(mk_read(9), next_gap(1'b0));
    send_item(mk_face(5, 1023, 32'h0000_0000, 32'h0000_0000), next_gap(1'b0));
    send_item(mk_face(1023, 5, 32'h8000_0000, 32'h7FFF_FFFF), next_gap(1'b0));
    send_item(mk_read(1023), next_gap(1'b0));
    send_item(mk_read(5), next_gap(1'b0));
  endtask

  task automatic test_reload_and_unused_code;
    send_item(mk_unused(), next_gap(1'b0));
    // reload clears the saturation mark
    send_item(mk_load(0, 32'h0001_0000, 32'hFFFF_0000), next_gap(1'b0));
    send_item(mk_read(0), next_gap(1'b0));
    send_item(mk_unused(), next_gap(1'b0));
    send_item(mk_read(9), next_gap(1'b0));
  endtask

  task automatic test_random_traffic;
    int target;
    int n_cells;
    int n_faces;
    int mode;
    int k;
    int c;
    int l;
    int u;
    bit calm;
    bit neg;
    int ws[$];
    target = load_count + face_count + read_count + RANDOM_ITEMS;
    while (load_count + face_count + read_count < target) begin
      mode    = $urandom_range(0, 3);
      calm    = ($urandom_range(0, 3) == 0);
      neg     = 1'($urandom_range(0, 1));
      n_cells = $urandom_range(1, 6);
      ws.delete();
      for (k = 0; k < n_cells; k++) begin
        if (loaded_list.size() > 0 && $urandom_range(0, 2) == 0) begin
          c = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
          ws.push_back(c);
          if ($urandom_range(0, 1))
            send_item(mk_load(c, pick_q(mode, neg), pick_q(mode, 1'b0)), next_gap(calm));
        end else begin
          c = $urandom_range(0, MAX_CELLS - 1);
          ws.push_back(c);
          send_item(mk_load(c, pick_q(mode, neg), pick_q(mode, 1'b0)), next_gap(calm));
        end
      end
      n_faces = $urandom_range(0, 12);
      for (k = 0; k < n_faces; k++) begin
        l = ws[$urandom_range(0, ws.size() - 1)];
        u = ($urandom_range(0, 7) == 0) ? l : ws[$urandom_range(0, ws.size() - 1)];
        if ($urandom_range(0, 9) == 0)
          u = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
        send_item(mk_face(l, u, pick_q(mode, neg), pick_q(mode, neg)), next_gap(calm));
        if ($urandom_range(0, 3) == 0)
          send_item(mk_read(ws[$urandom_range(0, ws.size() - 1)]), next_gap(calm));
        if ($urandom_range(0, 15) == 0)
          send_item(mk_unused(), next_gap(calm));
      end
      foreach (ws[i])
        send_item(mk_read(ws[i]), next_gap(calm));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      result_count++;
      if (saturated === 1'b1) sat_reads++;
      if (pending_products.size() == 0) begin
        $display("%0t: result with none expected, got cell %0d product %0d", $time,
                 result_cell, product_value);
        error_count++;
      end else begin
        want = pending_products.pop_front();
        if (result_cell !== want.cell_id) begin
          $display("%0t: result_cell expected %0d got %0d", $time, want.cell_id,
                   result_cell);
          error_count++;
        end
        if (product_value !== want.value) begin
          $display("%0t: cell %0d product_value expected %0d got %0d", $time,
                   want.cell_id, want.value, product_value);
          error_count++;
        end
        if (saturated !== want.sat) begin
          $display("%0t: cell %0d saturated expected %0b got %0b", $time, want.cell_id,
                   want.sat, saturated);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_products.size());
      $display("ldu_sparse_matvec test failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);
    test_load_read_extremes;
    test_face_saturation;
    test_reload_and_unused_code;
    test_random_traffic;
    start <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d loads, %0d faces, %0d reads, %0d unused codes", load_count,
             face_count, read_count, ignored_count);
    $display("checked %0d products, %0d with the saturation mark set, %0d mismatches",
             result_count, sat_reads, error_count);
    if (error_count == 0)
      $display("ldu_sparse_matvec test passed");
    else
      $display("ldu_sparse_matvec test failed");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/lsm_pkg.sv
rtl/lsm_ctrl.sv
rtl/lsm_datapath.sv
rtl/ldu_sparse_matvec.sv
rtl/lsm_checker.sv
tb/sv/ldu_sparse_matvec_tb.sv
